### rtl/core/tbr_pkg.sv
// shared widths, defaults and constants of the tick bar rsi/atr tracker
// no dependencies
package tbr_pkg;

    localparam int PRICE_W = 24;
    localparam int MID_W   = 25;
    localparam int TIME_W  = 44;
    localparam int RSI_W   = 15;
    localparam int ATR_W   = 37;
    localparam int MIN_W   = 29;

    localparam int RSI_WINDOW_DEF = 14;
    localparam int ATR_WINDOW_DEF = 14;

    // 25600 = 100 * 256 = (2^14 + 2^13 + 2^10)
    localparam int RSI_SCALE_W = 15;
    localparam logic [RSI_W-1:0] RSI_FIFTY = 15'd12800;
    localparam logic [RSI_W-1:0] RSI_FULL  = 15'd25600;

    // bar index t / 60000 = (t >> 5) / 1875, with t >> 5 split at bit 20
    // 2^20 = 1875 * 559 + 451; low quotient by ceil(2^39 / 1875), exact below 2^28
    localparam longint BAR_PERIOD_MS = 60000;
    localparam int BAR_SHIFT  = 5;
    localparam int BAR_LOW_W  = 20;
    localparam int BAR_HI_W   = 19;
    localparam int BAR_Y_W    = 28;
    localparam int BAR_REC_W  = 29;
    localparam int BAR_REC_SH = 39;
    localparam int BAR_Q0     = 559;
    localparam int BAR_R0     = 451;
    localparam logic [BAR_REC_W-1:0] BAR_RECIP = 29'd293203101;

endpackage

### rtl/core/tbr_tick_if.sv
// tick channel: valid/ready handshake with bid, ask and time payload
// depends on tbr_pkg
interface tbr_tick_if
    import tbr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PRICE_W-1:0]  bid_price;
    logic [PRICE_W-1:0]  ask_price;
    logic [TIME_W-1:0]   time_ms;

    modport source (output valid, bid_price, ask_price, time_ms, input ready);
    modport sink   (input valid, bid_price, ask_price, time_ms, output ready);
endinterface

### rtl/core/tbr_result_if.sv
// result channel: valid/ready handshake with bar, atr and rsi payload
// depends on tbr_pkg
interface tbr_result_if
    import tbr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              new_bar;
    logic [MID_W-1:0]  bar_high;
    logic [MID_W-1:0]  bar_low;
    logic              history_ready;
    logic [ATR_W-1:0]  atr_q8;
    logic [RSI_W-1:0]  rsi_q8;

    modport source (output valid, new_bar, bar_high, bar_low, history_ready, atr_q8, rsi_q8,
                    input ready);
    modport sink   (input valid, new_bar, bar_high, bar_low, history_ready, atr_q8, rsi_q8,
                    output ready);
endinterface

### rtl/core/tbr_ram.sv
// simple dual-port ram, one write and one registered read per cycle
// no dependencies
module tbr_ram #(
    parameter int W     = 50,
    parameter int DEPTH = 14
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [W-1:0]                            wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [W-1:0]                            rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/tbr_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies
module tbr_div #(
    parameter int DIVW = 44,
    parameter int DSW  = 30
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DIVW-1:0] dividend,
    input  logic [DSW-1:0]  divisor,
    output logic            done,
    output logic [DIVW-1:0] quotient
);
    localparam int CntW = $clog2(DIVW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CntW-1:0] cnt_reg;
    logic [DSW-1:0]  rem_reg;
    logic [DIVW-1:0] quo_reg;
    logic [DSW:0]    rem_sh;
    logic [DSW:0]    rem_sub;
    logic            ge;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DIVW-1]};
        ge      = (rem_sh >= {1'b0, divisor});
        rem_sub = rem_sh - {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CntW'(DIVW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[DSW-1:0] : rem_sh[DSW-1:0];
            quo_reg <= {quo_reg[DIVW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

### rtl/core/tick_bar_rsi_atr_tracker_top.sv
// tick bar tracker top: sequencer, move and true range windows, shared divider
// depends on tbr_pkg, tbr_tick_if, tbr_result_if, tbr_ram, tbr_div
//
//  channel  dir  payload                                              handshake
//  tick     in   bid_price, ask_price, time_ms                        valid/ready
//  result   out  new_bar, bar_high, bar_low, history_ready, atr, rsi  valid/ready
//
// a tick runs S_MIN, S_MOVE, S_RSI (not on the first tick), S_BAR, S_TR and S_ATR for a closed
// bar with history, then S_OUT, which waits out result stalls; the bar index comes from a
// constant reciprocal multiply in S_IDLE, S_MIN and S_MOVE; rsi uses one pass of the shared
// bit-serial divider once its window is full with losses, a closed bar with history uses another
// tick.ready is high only while idle; the result waits in registers for result.ready
// reset is asynchronous; no clearing pass, windows are tracked by fill counts
module tick_bar_rsi_atr_tracker_top
    import tbr_pkg::*;
#(
    parameter int RSI_WINDOW = RSI_WINDOW_DEF,
    parameter int ATR_WINDOW = ATR_WINDOW_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tbr_tick_if.sink      tick,
    tbr_result_if.source  result
);
    localparam int RposW  = $clog2(RSI_WINDOW);
    localparam int RfillW = $clog2(RSI_WINDOW + 1);
    localparam int TotW   = MID_W + $clog2(RSI_WINDOW);
    localparam int NumW   = TotW + RSI_SCALE_W;
    localparam int ApW    = (ATR_WINDOW > 1) ? $clog2(ATR_WINDOW) : 1;
    localparam int AfillW = $clog2(ATR_WINDOW + 1);
    localparam int BarsW  = $clog2(ATR_WINDOW + 2);
    localparam int TrsW   = MID_W + $clog2(ATR_WINDOW);
    localparam int DivW   = (NumW > TrsW + 8) ? NumW : TrsW + 8;
    localparam int DsW    = (TotW + 1 > AfillW) ? TotW + 1 : AfillW;
    localparam int ProdW  = BAR_Y_W + BAR_REC_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MIN, S_MOVE, S_RSI, S_RSI_WAIT, S_BAR, S_TR, S_ATR, S_ATR_WAIT, S_OUT
    } state_t;

    state_t              state_reg;
    logic [MID_W-1:0]    mid_reg;
    logic [MID_W-1:0]    prev_mid_reg;
    logic                prev_valid_reg;
    logic [RposW-1:0]    rsi_pos_reg;
    logic [RfillW-1:0]   rsi_fill_reg;
    logic [TotW-1:0]     gain_total_reg;
    logic [TotW-1:0]     loss_total_reg;
    logic [RSI_W-1:0]    rsi_hold_reg;
    logic [ATR_W-1:0]    atr_hold_reg;
    logic                bar_started_reg;
    logic [MIN_W-1:0]    bar_minute_reg;
    logic [MIN_W-1:0]    minute_reg;
    logic [BAR_Y_W-1:0]  y_reg;
    logic [MIN_W-1:0]    hq_reg;
    logic [ProdW-1:0]    prod_reg;
    logic [MID_W-1:0]    cur_high_reg;
    logic [MID_W-1:0]    cur_low_reg;
    logic [MID_W-1:0]    cur_close_reg;
    logic [MID_W-1:0]    last_close_reg;
    logic [BarsW-1:0]    bars_reg;
    logic [ApW-1:0]      tr_pos_reg;
    logic [AfillW-1:0]   tr_fill_reg;
    logic [TrsW-1:0]     tr_total_reg;
    logic [MID_W-1:0]    tr_new_reg;
    logic                new_bar_reg;
    logic [MID_W-1:0]    bar_high_reg;
    logic [MID_W-1:0]    bar_low_reg;
    logic                div_start_reg;
    logic [DivW-1:0]     div_dvd_reg;
    logic [DsW-1:0]      div_dsr_reg;

    logic                div_done;
    logic [DivW-1:0]     div_quo;
    logic                rsi_we;
    logic [2*MID_W-1:0]  rsi_rdata;
    logic                tr_we;
    logic [MID_W-1:0]    tr_rdata;

    logic [MID_W-1:0]    mv_gain;
    logic [MID_W-1:0]    mv_loss;
    logic                rsi_full;
    logic                tr_full;
    logic [MID_W-1:0]    tr_a;
    logic [MID_W-1:0]    tr_b;
    logic [MID_W-1:0]    tr_c;
    logic [MID_W-1:0]    tr_max;
    logic [NumW-1:0]     rsi_num;

    tbr_div #(.DIVW(DivW), .DSW(DsW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (div_dsr_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    tbr_ram #(.W(2*MID_W), .DEPTH(RSI_WINDOW)) u_move_ram (
        .clk   (clk),
        .we    (rsi_we),
        .waddr (rsi_pos_reg),
        .wdata ({mv_gain, mv_loss}),
        .raddr (rsi_pos_reg),
        .rdata (rsi_rdata)
    );

    tbr_ram #(.W(MID_W), .DEPTH(ATR_WINDOW)) u_tr_ram (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_pos_reg),
        .wdata (tr_new_reg),
        .raddr (tr_pos_reg),
        .rdata (tr_rdata)
    );

    always_comb
    begin
        mv_gain  = (mid_reg > prev_mid_reg) ? mid_reg - prev_mid_reg : '0;
        mv_loss  = (mid_reg < prev_mid_reg) ? prev_mid_reg - mid_reg : '0;
        rsi_full = (rsi_fill_reg == RfillW'(RSI_WINDOW));
        tr_full  = (tr_fill_reg == AfillW'(ATR_WINDOW));
        rsi_we   = (state_reg == S_MOVE) && prev_valid_reg;
        tr_we    = (state_reg == S_TR);
        tr_a     = cur_high_reg - cur_low_reg;
        tr_b     = (cur_high_reg > last_close_reg) ? cur_high_reg - last_close_reg
                                                   : last_close_reg - cur_high_reg;
        tr_c     = (cur_low_reg > last_close_reg) ? cur_low_reg - last_close_reg
                                                  : last_close_reg - cur_low_reg;
        tr_max   = tr_a;
        if (tr_b > tr_max)
        begin
            tr_max = tr_b;
        end
        if (tr_c > tr_max)
        begin
            tr_max = tr_c;
        end
        rsi_num  = (NumW'(gain_total_reg) << 14) + (NumW'(gain_total_reg) << 13)
                 + (NumW'(gain_total_reg) << 10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mid_reg         <= '0;
            prev_mid_reg    <= '0;
            prev_valid_reg  <= 1'b0;
            rsi_pos_reg     <= '0;
            rsi_fill_reg    <= '0;
            gain_total_reg  <= '0;
            loss_total_reg  <= '0;
            rsi_hold_reg    <= RSI_FIFTY;
            atr_hold_reg    <= '0;
            bar_started_reg <= 1'b0;
            bar_minute_reg  <= '0;
            minute_reg      <= '0;
            y_reg           <= '0;
            hq_reg          <= '0;
            prod_reg        <= '0;
            cur_high_reg    <= '0;
            cur_low_reg     <= '0;
            cur_close_reg   <= '0;
            last_close_reg  <= '0;
            bars_reg        <= '0;
            tr_pos_reg      <= '0;
            tr_fill_reg     <= '0;
            tr_total_reg    <= '0;
            tr_new_reg      <= '0;
            new_bar_reg     <= 1'b0;
            bar_high_reg    <= '0;
            bar_low_reg     <= '0;
            div_start_reg   <= 1'b0;
            div_dvd_reg     <= '0;
            div_dsr_reg     <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (tick.valid)
                    begin
                        mid_reg      <= MID_W'(tick.bid_price) + MID_W'(tick.ask_price);
                        new_bar_reg  <= 1'b0;
                        bar_high_reg <= '0;
                        bar_low_reg  <= '0;
                        y_reg        <= BAR_Y_W'(tick.time_ms[TIME_W-1 -: BAR_HI_W])
                                      * BAR_Y_W'(BAR_R0)
                                      + BAR_Y_W'(tick.time_ms[BAR_SHIFT +: BAR_LOW_W]);
                        hq_reg       <= MIN_W'(tick.time_ms[TIME_W-1 -: BAR_HI_W])
                                      * MIN_W'(BAR_Q0);
                        state_reg    <= S_MIN;
                    end
                end
                S_MIN:
                begin
                    prod_reg  <= ProdW'(y_reg) * ProdW'(BAR_RECIP);
                    state_reg <= S_MOVE;
                end
                S_MOVE:
                begin
                    minute_reg     <= hq_reg + MIN_W'(prod_reg[ProdW-1:BAR_REC_SH]);
                    prev_mid_reg   <= mid_reg;
                    prev_valid_reg <= 1'b1;
                    if (prev_valid_reg)
                    begin
                        gain_total_reg <= gain_total_reg
                                        - (rsi_full ? TotW'(rsi_rdata[2*MID_W-1:MID_W]) : '0)
                                        + TotW'(mv_gain);
                        loss_total_reg <= loss_total_reg
                                        - (rsi_full ? TotW'(rsi_rdata[MID_W-1:0]) : '0)
                                        + TotW'(mv_loss);
                        if (!rsi_full)
                        begin
                            rsi_fill_reg <= rsi_fill_reg + 1'b1;
                        end
                        rsi_pos_reg <= (rsi_pos_reg == RposW'(RSI_WINDOW - 1))
                                     ? '0 : rsi_pos_reg + 1'b1;
                        state_reg   <= S_RSI;
                    end
                    else
                    begin
                        state_reg <= S_BAR;
                    end
                end
                S_RSI:
                begin
                    if (!rsi_full)
                    begin
                        state_reg <= S_BAR;
                    end
                    else if (loss_total_reg == '0)
                    begin
                        rsi_hold_reg <= RSI_FULL;
                        state_reg    <= S_BAR;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= DivW'(rsi_num);
                        div_dsr_reg   <= DsW'(gain_total_reg) + DsW'(loss_total_reg);
                        state_reg     <= S_RSI_WAIT;
                    end
                end
                S_RSI_WAIT:
                begin
                    if (div_done)
                    begin
                        rsi_hold_reg <= div_quo[RSI_W-1:0];
                        state_reg    <= S_BAR;
                    end
                end
                S_BAR:
                begin
                    state_reg <= S_OUT;
                    if (!bar_started_reg)
                    begin
                        bar_started_reg <= 1'b1;
                        bar_minute_reg  <= minute_reg;
                        cur_high_reg    <= mid_reg;
                        cur_low_reg     <= mid_reg;
                        cur_close_reg   <= mid_reg;
                    end
                    else if (minute_reg != bar_minute_reg)
                    begin
                        new_bar_reg    <= 1'b1;
                        bar_high_reg   <= cur_high_reg;
                        bar_low_reg    <= cur_low_reg;
                        tr_new_reg     <= tr_max;
                        last_close_reg <= cur_close_reg;
                        if (bars_reg != BarsW'(ATR_WINDOW + 1))
                        begin
                            bars_reg <= bars_reg + 1'b1;
                        end
                        if (bars_reg != '0)
                        begin
                            state_reg <= S_TR;
                        end
                        bar_minute_reg <= minute_reg;
                        cur_high_reg   <= mid_reg;
                        cur_low_reg    <= mid_reg;
                        cur_close_reg  <= mid_reg;
                    end
                    else
                    begin
                        if (mid_reg > cur_high_reg)
                        begin
                            cur_high_reg <= mid_reg;
                        end
                        if (mid_reg < cur_low_reg)
                        begin
                            cur_low_reg <= mid_reg;
                        end
                        cur_close_reg <= mid_reg;
                    end
                end
                S_TR:
                begin
                    tr_total_reg <= tr_total_reg - (tr_full ? TrsW'(tr_rdata) : '0)
                                  + TrsW'(tr_new_reg);
                    if (!tr_full)
                    begin
                        tr_fill_reg <= tr_fill_reg + 1'b1;
                    end
                    tr_pos_reg <= (tr_pos_reg == ApW'(ATR_WINDOW - 1)) ? '0 : tr_pos_reg + 1'b1;
                    state_reg  <= S_ATR;
                end
                S_ATR:
                begin
                    div_start_reg <= 1'b1;
                    div_dvd_reg   <= DivW'(tr_total_reg) << 8;
                    div_dsr_reg   <= DsW'(tr_fill_reg);
                    state_reg     <= S_ATR_WAIT;
                end
                S_ATR_WAIT:
                begin
                    if (div_done)
                    begin
                        atr_hold_reg <= div_quo[ATR_W-1:0];
                        state_reg    <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (result.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign tick.ready           = (state_reg == S_IDLE);
    assign result.valid         = (state_reg == S_OUT);
    assign result.new_bar       = new_bar_reg;
    assign result.bar_high      = bar_high_reg;
    assign result.bar_low       = bar_low_reg;
    assign result.history_ready = (bars_reg >= BarsW'(2));
    assign result.atr_q8        = atr_hold_reg;
    assign result.rsi_q8        = rsi_hold_reg;

    a_rsi_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsi_fill_reg <= RfillW'(RSI_WINDOW))
        else $error("rsi window fill count overflow");

    a_tr_fill: assert property (@(posedge clk) disable iff (!rst_n)
        tr_fill_reg <= AfillW'(ATR_WINDOW))
        else $error("true range window fill count overflow");

    a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsi_hold_reg <= RSI_FULL)
        else $error("rsi above full scale");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid && tick.ready |=> !result.valid)
        else $error("result presented in the cycle after a tick transaction");

    a_bar_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.new_bar |-> result.bar_high == '0 && result.bar_low == '0)
        else $error("bar fields set without a closed bar");
endmodule
